/* hdl/sspu_pkg.sv */
// Shared constants and tables for the sprite screen projection unit.
// Used by the CORDIC stages, the top level and the port checker.
`default_nettype none

package sspu_pkg;

    localparam int SCREEN_COLUMNS_DEF = 320;

    localparam int COORD_W = 16;
    localparam int HDG_W   = 9;
    localparam int FOV_W   = 8;
    localparam int COL_W   = 9;
    localparam int DIST_W  = 25;
    localparam int BEAR_W  = 17;
    localparam int ANG_W   = 15;
    localparam int SQRT_VW = 50;
    localparam int R_W     = 25;
    localparam int COS_W   = 31;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FOV_W-1:0] FOV_RESET = 8'd60;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_XW    = 35;
    localparam int CORDIC_ZW    = 26;

    // atan(2^-i) in degrees, Q.16
    localparam logic signed [CORDIC_ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    localparam logic signed [CORDIC_XW-1:0] INV_GAIN_Q30 = 35'sd652032874;
    localparam logic [COS_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [BEAR_W-1:0] DEG90_Q8  = 17'd23040;
    localparam logic [BEAR_W-1:0] DEG180_Q8 = 17'd46080;
    localparam logic [BEAR_W-1:0] DEG270_Q8 = 17'd69120;
    localparam logic [BEAR_W-1:0] DEG360_Q8 = 17'd92160;

    localparam logic [HDG_W-1:0] DEG360 = 9'd360;
    localparam logic [HDG_W-1:0] COS_LIMIT_HALF_DEG = 9'd180;

endpackage

`default_nettype wire

/* hdl/sspu_cordic.sv */
// Fully pipelined 16-step CORDIC, one micro-rotation per register stage.
// Vectoring or rotation direction is picked by the vectoring input; uses sspu_pkg.
`default_nettype none

module sspu_cordic (
    input  wire logic                                   aclk,
    input  wire logic                                   ce,
    input  wire logic                                   vectoring,
    input  wire logic signed [sspu_pkg::CORDIC_XW-1:0] x_in,
    input  wire logic signed [sspu_pkg::CORDIC_XW-1:0] y_in,
    input  wire logic signed [sspu_pkg::CORDIC_ZW-1:0] z_in,
    output logic signed [sspu_pkg::CORDIC_XW-1:0]      x_out,
    output logic signed [sspu_pkg::CORDIC_XW-1:0]      y_out,
    output logic signed [sspu_pkg::CORDIC_ZW-1:0]      z_out
);

    localparam int N  = sspu_pkg::CORDIC_STEPS;
    localparam int XW = sspu_pkg::CORDIC_XW;
    localparam int ZW = sspu_pkg::CORDIC_ZW;

    logic signed [XW-1:0] x_reg [N];
    logic signed [XW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [XW-1:0] x_cur;
        logic signed [XW-1:0] y_cur;
        logic signed [ZW-1:0] z_cur;
        logic                 turn_pos;

        if (k == 0) begin : g_first
            assign x_cur = x_in;
            assign y_cur = y_in;
            assign z_cur = z_in;
        end else begin : g_next
            assign x_cur = x_reg[k-1];
            assign y_cur = y_reg[k-1];
            assign z_cur = z_reg[k-1];
        end

        // both modes share the update; only the steering test differs
        assign turn_pos = vectoring ? (y_cur > 0) : (z_cur < 0);

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (turn_pos) begin
                    x_reg[k] <= x_cur + (y_cur >>> k);
                    y_reg[k] <= y_cur - (x_cur >>> k);
                    z_reg[k] <= z_cur + sspu_pkg::ATAN_Q16[k];
                end else begin
                    x_reg[k] <= x_cur - (y_cur >>> k);
                    y_reg[k] <= y_cur + (x_cur >>> k);
                    z_reg[k] <= z_cur - sspu_pkg::ATAN_Q16[k];
                end
            end
        end
    end

    assign x_out = x_reg[N-1];
    assign y_out = y_reg[N-1];
    assign z_out = z_reg[N-1];

endmodule

`default_nettype wire

/* hdl/sspu_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// The user must hold the divisor steady while items are in flight; the block does not enforce it. No package use.
`default_nettype none

module sspu_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  wire logic          aclk,
    input  wire logic          ce,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic [QW-1:0]      quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [CW-1:0] rem_cur;
        logic [QW-1:0] quo_cur;
        logic [CW-1:0] trial;
        logic          fits;

        if (k == 0) begin : g_first
            assign rem_cur = CW'(num);
            assign quo_cur = '0;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign quo_cur = quo_reg[k-1];
        end

        assign trial = CW'(den) << (QW - 1 - k);
        assign fits  = rem_cur >= trial;

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= fits ? rem_cur - trial : rem_cur;
                quo_reg[k] <= quo_cur | (QW'(fits) << (QW - 1 - k));
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

/* hdl/sprite_screen_projection_unit.sv */
// Sprite screen projection: bearing, field-of-view test, screen column and
// fisheye-corrected distance for one object per beat. Uses sspu_pkg, sspu_cordic, sspu_div.
//
// One beat is accepted every clock while no result is stalled; the path runs through the
// two 16-stage CORDICs and the bit-per-stage column divider in series. The whole pipeline
// freezes while a result waits on m_tready. The user must see that field_of_view is written
// through cfg_we/cfg_wdata only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module sprite_screen_projection_unit #(
    parameter int SCREEN_COLUMNS = sspu_pkg::SCREEN_COLUMNS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [sspu_pkg::FOV_W-1:0]          cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // viewer_x[15:0], viewer_y[31:16], viewer_heading[40:32],
    // object_x[56:41], object_y[72:57], zero pad[79:73]
    input  wire logic [sspu_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // visible[0], screen_column[9:1], corrected_distance[34:10], zero pad[39:35]
    output logic [sspu_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int CW_  = sspu_pkg::COORD_W;
    localparam int HW   = sspu_pkg::HDG_W;
    localparam int FW   = sspu_pkg::FOV_W;
    localparam int BW   = sspu_pkg::BEAR_W;
    localparam int XW   = sspu_pkg::CORDIC_XW;
    localparam int ZW   = sspu_pkg::CORDIC_ZW;
    localparam int VW   = sspu_pkg::SQRT_VW;
    localparam int RW   = sspu_pkg::R_W;
    localparam int KW   = sspu_pkg::COS_W;
    localparam int AW   = sspu_pkg::ANG_W;
    localparam int SCW  = $clog2(SCREEN_COLUMNS + 1);
    localparam int N1W  = BW + SCW - 8;
    localparam int QW2  = 8;
    localparam int RSTEPS = VW / 2;

    // reciprocal of the column count, exact for products of SCW+FW bits
    localparam int QS  = 2 * SCW + FW;
    localparam int MW  = SCW + FW + 2;
    localparam int RQW = SCW + FW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << QS) + 64'(SCREEN_COLUMNS - 1)) / 64'(SCREEN_COLUMNS));

    localparam int ST_Z    = 1 + sspu_pkg::CORDIC_STEPS;
    localparam int ST_A    = ST_Z + 1;
    localparam int ST_B    = ST_A + 1;
    localparam int ST_W    = ST_B + 1;
    localparam int ST_N    = ST_W + 1;
    localparam int ST_COL  = ST_N + SCW;
    localparam int ST_OFF  = ST_COL + 1;
    localparam int ST_PROD = ST_OFF + 1;
    localparam int ST_Q    = ST_PROD + 1;
    localparam int ST_T    = ST_Q + 1;
    localparam int ST_COS  = ST_T + sspu_pkg::CORDIC_STEPS;
    localparam int ST_CL   = ST_COS + 1;
    localparam int ST_OUT  = ST_CL + 1;
    localparam int ST_R    = 3 + RSTEPS;

    localparam logic [SCW-1:0] SC_VAL  = SCW'(SCREEN_COLUMNS);
    localparam logic [SCW-1:0] SC_HALF = SCW'(SCREEN_COLUMNS / 2);

    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
    } quad_t;

    logic          pipe_ce;
    logic [FW-1:0] fov_reg;
    logic          vld_reg [ST_OUT];

    assign pipe_ce  = !vld_reg[ST_OUT-1] || m_tready;
    assign s_tready = pipe_ce;
    assign m_tvalid = vld_reg[ST_OUT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_reg <= sspu_pkg::FOV_RESET;
        end else if (cfg_we) begin
            fov_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ST_OUT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (pipe_ce) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < ST_OUT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: deltas, quadrant, window edges
    logic [CW_-1:0] ax_reg, ay_reg, ax_next, ay_next;
    quad_t          quad_reg, quad_next;
    logic [HW-1:0]  mn_reg, mx_reg, mn_next, mx_next;

    always_comb begin
        logic signed [CW_:0] dx, dy;
        logic [HW-1:0] h, hw, half;
        logic [HW:0]   hi;
        dx = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, s_tdata[56:41]});
        dy = $signed({1'b0, s_tdata[31:16]}) - $signed({1'b0, s_tdata[72:57]});
        ax_next = dx < 0 ? CW_'(-dx) : CW_'(dx);
        ay_next = dy < 0 ? CW_'(-dy) : CW_'(dy);
        quad_next.dx_zero = dx == 0;
        quad_next.dx_neg  = dx < 0;
        quad_next.dy_zero = dy == 0;
        quad_next.dy_neg  = dy < 0;
        h    = s_tdata[40:32];
        hw   = h >= sspu_pkg::DEG360 ? h - sspu_pkg::DEG360 : h;
        half = HW'(fov_reg >> 1);
        mn_next = hw >= half ? hw - half : hw + sspu_pkg::DEG360 - half;
        hi   = {1'b0, hw} + {1'b0, half};
        mx_next = hi >= {1'b0, sspu_pkg::DEG360} ? HW'(hi - {1'b0, sspu_pkg::DEG360})
                                                 : HW'(hi);
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            quad_reg <= quad_next;
            mn_reg   <= mn_next;
            mx_reg   <= mx_next;
        end
    end

    // ---------------- distance: squares, sum, square root
    logic [2*CW_-1:0] sqx_reg, sqy_reg;
    logic [VW-1:0]    sum_reg;
    logic [VW-1:0]    isq_v_reg [RSTEPS];
    logic [VW-1:0]    isq_r_reg [RSTEPS];

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
            sum_reg <= VW'((VW'(sqx_reg) + VW'(sqy_reg)) << 16);
        end
    end

    for (genvar k = 0; k < RSTEPS; k++) begin : g_isqrt
        logic [VW-1:0] v_cur, r_cur, trial;
        localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
        if (k == 0) begin : g_first
            assign v_cur = sum_reg;
            assign r_cur = '0;
        end else begin : g_next
            assign v_cur = isq_v_reg[k-1];
            assign r_cur = isq_r_reg[k-1];
        end
        assign trial = r_cur + BIT;
        always_ff @(posedge aclk) begin
            if (pipe_ce) begin
                if (v_cur >= trial) begin
                    isq_v_reg[k] <= v_cur - trial;
                    isq_r_reg[k] <= (r_cur >> 1) + BIT;
                end else begin
                    isq_v_reg[k] <= v_cur;
                    isq_r_reg[k] <= r_cur >> 1;
                end
            end
        end
    end

    // ---------------- bearing: atan CORDIC
    logic signed [XW-1:0] at_x, at_y;
    logic signed [ZW-1:0] at_z;

    sspu_cordic u_atan (
        .aclk      (aclk),
        .ce        (pipe_ce),
        .vectoring (1'b1),
        .x_in      ($signed(XW'({ax_reg, 16'h0000}))),
        .y_in      ($signed(XW'({ay_reg, 16'h0000}))),
        .z_in      ('0),
        .x_out     (at_x),
        .y_out     (at_y),
        .z_out     (at_z)
    );

    quad_t         quad_dly_reg [ST_A-1];
    logic [2*HW-1:0] edge_dly_reg [ST_B-1];

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            quad_dly_reg[0] <= quad_reg;
            for (int i = 1; i < ST_A - 1; i++) begin
                quad_dly_reg[i] <= quad_dly_reg[i-1];
            end
            edge_dly_reg[0] <= {mn_reg, mx_reg};
            for (int i = 1; i < ST_B - 1; i++) begin
                edge_dly_reg[i] <= edge_dly_reg[i-1];
            end
        end
    end

    // round to Q.8 and clamp to 0..90 degrees
    logic [AW-1:0] ang_reg, ang_next;

    always_comb begin
        logic [ZW-1:0] zp, zr;
        zp = at_z < 0 ? '0 : ZW'(at_z);
        zr = (zp + ZW'(128)) >> 8;
        ang_next = zr > ZW'(sspu_pkg::DEG90_Q8) ? AW'(sspu_pkg::DEG90_Q8) : AW'(zr);
    end

    logic [BW-1:0] bear_reg, bear_next;

    always_comb begin
        quad_t         qd;
        logic [BW-1:0] ae, b;
        qd = quad_dly_reg[ST_A-2];
        ae = qd.dy_zero ? '0 : BW'(ang_reg);
        if (qd.dx_zero) begin
            b = qd.dy_neg ? sspu_pkg::DEG270_Q8 : sspu_pkg::DEG90_Q8;
        end else if (!qd.dx_neg) begin
            b = qd.dy_neg ? sspu_pkg::DEG180_Q8 + ae : sspu_pkg::DEG180_Q8 - ae;
        end else begin
            b = qd.dy_neg ? sspu_pkg::DEG360_Q8 - ae : ae;
        end
        bear_next = b >= sspu_pkg::DEG360_Q8 ? b - sspu_pkg::DEG360_Q8 : b;
    end

    // ---------------- window test and angle from the upper edge
    logic          out_reg, out_next;
    logic [BW-1:0] diff_reg, diff_next;

    always_comb begin
        logic [HW-1:0] mn, mx;
        logic [BW-1:0] mn8, mx8;
        logic [BW:0]   wrap;
        {mn, mx} = edge_dly_reg[ST_B-2];
        mn8 = {mn, 8'h00};
        mx8 = {mx, 8'h00};
        if (mn > mx) begin
            out_next = (bear_reg < mn8) && (bear_reg > mx8);
        end else begin
            out_next = (bear_reg < mn8) || (bear_reg > mx8);
        end
        wrap = {1'b0, mx8} + {1'b0, sspu_pkg::DEG360_Q8} - {1'b0, bear_reg};
        diff_next = bear_reg > mx8 ? BW'(wrap) : mx8 - bear_reg;
    end

    logic [N1W-1:0] n1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            ang_reg  <= ang_next;
            bear_reg <= bear_next;
            out_reg  <= out_next;
            diff_reg <= diff_next;
            n1_reg   <= N1W'(((BW + SCW)'(diff_reg) * (BW + SCW)'(SC_VAL)) >> 8);
        end
    end

    // ---------------- column = angle * columns / fov
    logic [SCW-1:0] q1;

    sspu_div #(
        .NW (N1W),
        .DW (FW),
        .QW (SCW)
    ) u_col_div (
        .aclk (aclk),
        .ce   (pipe_ce),
        .num  (n1_reg),
        .den  (fov_reg),
        .quo  (q1)
    );

    logic [SCW-1:0]    col_reg, col_next, off_reg, off_next;
    logic [SCW+FW-1:0] prod_reg;
    logic [RQW-1:0]    rq_reg;

    always_comb begin
        col_next = fov_reg == '0 ? '0 : q1;
        off_next = col_next < SC_HALF ? col_next : SC_VAL - col_next;
    end

    // divide offset * fov by the column count through the reciprocal
    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            col_reg  <= col_next;
            off_reg  <= off_next;
            prod_reg <= (SCW + FW)'(off_reg) * (SCW + FW)'(fov_reg);
            rq_reg   <= RQW'(prod_reg) * RQW'(RECIP);
        end
    end

    logic [QW2-1:0] q2;

    assign q2 = rq_reg[QS +: QW2];

    // ---------------- column angle in half degrees and its cosine
    logic [HW-1:0] t2_reg, t2_next;
    logic          big_reg, big_next;

    always_comb begin
        logic signed [HW:0] t2s;
        t2s = $signed({2'b00, fov_reg}) - $signed({1'b0, q2, 1'b0});
        t2_next  = t2s < 0 ? HW'(-t2s) : HW'(t2s);
        big_next = t2_next > sspu_pkg::COS_LIMIT_HALF_DEG;
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            t2_reg  <= t2_next;
            big_reg <= big_next;
        end
    end

    logic signed [XW-1:0] cs_x, cs_y;
    logic signed [ZW-1:0] cs_z;

    sspu_cordic u_cos (
        .aclk      (aclk),
        .ce        (pipe_ce),
        .vectoring (1'b0),
        .x_in      (sspu_pkg::INV_GAIN_Q30),
        .y_in      ('0),
        .z_in      ($signed(ZW'({t2_reg, 15'h0000}))),
        .x_out     (cs_x),
        .y_out     (cs_y),
        .z_out     (cs_z)
    );

    logic big_dly_reg [ST_COS-ST_T];
    logic out_dly_reg [ST_CL-ST_W];
    logic [SCW-1:0] col_dly_reg [ST_CL-ST_OFF];
    logic [RW-1:0]  r_dly_reg [ST_CL-ST_R];

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            big_dly_reg[0] <= big_reg;
            for (int i = 1; i < ST_COS - ST_T; i++) begin
                big_dly_reg[i] <= big_dly_reg[i-1];
            end
            out_dly_reg[0] <= out_reg;
            for (int i = 1; i < ST_CL - ST_W; i++) begin
                out_dly_reg[i] <= out_dly_reg[i-1];
            end
            col_dly_reg[0] <= col_reg;
            for (int i = 1; i < ST_CL - ST_OFF; i++) begin
                col_dly_reg[i] <= col_dly_reg[i-1];
            end
            r_dly_reg[0] <= isq_r_reg[RSTEPS-1][RW-1:0];
            for (int i = 1; i < ST_CL - ST_R; i++) begin
                r_dly_reg[i] <= r_dly_reg[i-1];
            end
        end
    end

    // clamp cosine to [0, 1]; zero it past 90 degrees
    logic [KW-1:0] cos_reg, cos_next;

    always_comb begin
        if (big_dly_reg[ST_COS-ST_T-1] || cs_x < 0) begin
            cos_next = '0;
        end else if (cs_x > $signed(XW'(sspu_pkg::ONE_Q30))) begin
            cos_next = sspu_pkg::ONE_Q30;
        end else begin
            cos_next = KW'(cs_x);
        end
    end

    // ---------------- output register
    logic                        vis_reg;
    logic [sspu_pkg::COL_W-1:0]  scol_reg;
    logic [sspu_pkg::DIST_W-1:0] dist_reg;
    logic [RW+KW-1:0]            dist_prod;
    logic                        vis_now;

    assign vis_now   = !out_dly_reg[ST_CL-ST_W-1];
    assign dist_prod = (RW + KW)'(r_dly_reg[ST_CL-ST_R-1]) * (RW + KW)'(cos_reg);

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            cos_reg  <= cos_next;
            vis_reg  <= vis_now;
            scol_reg <= vis_now ? sspu_pkg::COL_W'(col_dly_reg[ST_CL-ST_OFF-1]) : '0;
            dist_reg <= vis_now ? dist_prod[30 +: sspu_pkg::DIST_W] : '0;
        end
    end

    assign m_tdata = {5'b00000, dist_reg, scol_reg, vis_reg};

endmodule

`default_nettype wire

/* hdl/sspu_checker.sv */
// Port-level checks for the sprite screen projection unit, bound to the top level.
// Depends on sspu_pkg for the result beat width.
`default_nettype none

module sspu_checker #(
    parameter int SCREEN_COLUMNS = sspu_pkg::SCREEN_COLUMNS_DEF
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [sspu_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // hidden objects carry neither a column nor a distance
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[34:1] == 34'd0)
        else $error("hidden object beat has nonzero column or distance");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("result beat pad bits set");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (SCREEN_COLUMNS > 511) ||
            (m_tdata[9:1] <= SCREEN_COLUMNS))
        else $error("screen column beyond screen width");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sprite_screen_projection_unit sspu_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
) u_sspu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
